// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ===== rtl/core/i2crts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2crts_pkg
// Types and constants of the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
package i2crts_pkg;

	localparam int COUNT_WIDTH = 16;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_START,
		PH_SLAW,
		PH_REG,
		PH_DATA,
		PH_REP,
		PH_SLAR,
		PH_RXACK,
		PH_RXNACK
	} phase_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_BURST = 2'd2,
		CMD_EVENT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_START = 3'd1,
		ACT_SEND  = 3'd2,
		ACT_ACK   = 3'd3,
		ACT_NACK  = 3'd4,
		ACT_STOP  = 3'd5
	} action_t;

	typedef enum logic [3:0] {
		RC_OK       = 4'd0,
		RC_START    = 4'd1,
		RC_SLAW     = 4'd2,
		RC_WRITE    = 4'd3,
		RC_REPSTART = 4'd4,
		RC_SLAR     = 4'd5,
		RC_READ     = 4'd6,
		RC_NACK     = 4'd7,
		RC_ACKERR   = 4'd8
	} rcode_t;

	// engine status codes after masking
	localparam logic [7:0] ST_MASK     = 8'hF8;
	localparam logic [7:0] ST_START    = 8'h08;
	localparam logic [7:0] ST_REPSTART = 8'h10;
	localparam logic [7:0] ST_SLAW_ACK = 8'h18;
	localparam logic [7:0] ST_DATA_ACK = 8'h28;
	localparam logic [7:0] ST_SLAR_ACK = 8'h40;
	localparam logic [7:0] ST_RX_ACK   = 8'h50;
	localparam logic [7:0] ST_RX_NACK  = 8'h58;
	localparam logic [7:0] BURST_FLAG  = 8'h80;

	typedef struct packed {
		logic [7:0]  engine_rx_byte;
		logic [7:0]  engine_status;
		logic [15:0] byte_count;
		logic [7:0]  write_data;
		logic [7:0]  register_address;
		logic [7:0]  device_address;
	} in_data_t;

	typedef struct packed {
		rcode_t     result_code;
		logic       finished;
		logic [7:0] rx_data;
		logic [7:0] tx_byte;
		action_t    action;
	} out_data_t;

	typedef struct packed {
		out_data_t data;
		logic      rx_valid;
		logic      rx_last;
	} result_t;

endpackage

// ===== rtl/core/i2c_register_transaction_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_register_transaction_sequencer
// Transaction sequencer above an I2C byte engine: register write, single read
// and burst read, checked step by step against the engine status codes.
// ----------------------------------------------------------------------------
// Usage:
//   Input words on s_*: s_tuser carries the command (request kind or engine
//   status event), s_tdata the request fields and the engine status/rx byte.
//   Each accepted word gives exactly one output word on m_*: the next engine
//   action, a byte to send, a received byte (m_tuser = byte valid, m_tlast =
//   last byte of the transaction), and completion with a result code.
//   The word accepted at one edge shows on m_* in the next cycle, from the
//   output register. Throughput is one word per cycle while the receiver
//   takes each word; the state update and the decode of the next action are a
//   single compare-and-select stage ahead of the output register.
//   When the receiver stalls, the output register holds its word and s_tready
//   falls until the word is taken; a word is accepted in the same cycle the
//   held one leaves.
//   Reset puts the sequencer idle with an empty output register.
//   A request while busy, or a status event while idle, answers action none.
//   A status mismatch ends the transaction with an error code and no stop.
// ----------------------------------------------------------------------------
module i2c_register_transaction_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] device_address, [15:8] register_address, [23:16] write_data,
	// [39:24] byte_count, [47:40] engine_status, [55:48] engine_rx_byte
	input  logic [55:0] s_tdata,
	// [1:0] command
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] action, [10:3] tx_byte, [18:11] rx_data, [19] finished,
	// [23:20] result_code
	output logic [23:0] m_tdata,
	// [0] rx_valid
	output logic        m_tuser,
	// rx_last
	output logic        m_tlast
);

	localparam int CW = i2crts_pkg::COUNT_WIDTH;

	i2crts_pkg::in_data_t  in_d;
	i2crts_pkg::cmd_t      cmd;
	logic [7:0]            st;
	logic                  s_accept;

	i2crts_pkg::phase_t    phase_q, phase_d;
	i2crts_pkg::cmd_t      kind_q, kind_d;
	logic [7:0]            sla_q, sla_d;
	logic [7:0]            reg_q, reg_d;
	logic [7:0]            pend_q, pend_d;
	logic [CW-1:0]         left_q, left_d;
	logic [CW-1:0]         left_dec;

	logic [7:0]            st_exp;
	logic                  st_ok;
	logic                  is_event;
	i2crts_pkg::result_t   res_d, res_q;
	logic                  m_valid_q;

	assign in_d     = i2crts_pkg::in_data_t'(s_tdata);
	assign cmd      = i2crts_pkg::cmd_t'(s_tuser);
	assign st       = in_d.engine_status & i2crts_pkg::ST_MASK;
	assign is_event = (cmd == i2crts_pkg::CMD_EVENT);
	assign left_dec = left_q - CW'(1);

	assign s_tready = !m_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	// expected engine status for the current phase
	always_comb begin
		case (phase_q)
			i2crts_pkg::PH_START:  st_exp = i2crts_pkg::ST_START;
			i2crts_pkg::PH_SLAW:   st_exp = i2crts_pkg::ST_SLAW_ACK;
			i2crts_pkg::PH_REG:    st_exp = i2crts_pkg::ST_DATA_ACK;
			i2crts_pkg::PH_DATA:   st_exp = i2crts_pkg::ST_DATA_ACK;
			i2crts_pkg::PH_REP:    st_exp = i2crts_pkg::ST_REPSTART;
			i2crts_pkg::PH_SLAR:   st_exp = i2crts_pkg::ST_SLAR_ACK;
			i2crts_pkg::PH_RXACK:  st_exp = i2crts_pkg::ST_RX_ACK;
			i2crts_pkg::PH_RXNACK: st_exp = i2crts_pkg::ST_RX_NACK;
			default:               st_exp = i2crts_pkg::ST_MASK;
		endcase
	end
	assign st_ok = (st == st_exp);

	// next state
	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		sla_d   = sla_q;
		reg_d   = reg_q;
		pend_d  = pend_q;
		left_d  = left_q;
		if (!is_event) begin
			if (phase_q == i2crts_pkg::PH_IDLE) begin
				kind_d  = cmd;
				sla_d   = in_d.device_address;
				reg_d   = in_d.register_address;
				pend_d  = in_d.write_data;
				left_d  = in_d.byte_count[CW-1:0];
				phase_d = i2crts_pkg::PH_START;
			end
		end else if (!st_ok) begin
			phase_d = i2crts_pkg::PH_IDLE;
		end else begin
			case (phase_q)
				i2crts_pkg::PH_START: phase_d = i2crts_pkg::PH_SLAW;
				i2crts_pkg::PH_SLAW:  phase_d = i2crts_pkg::PH_REG;
				i2crts_pkg::PH_REG: begin
					phase_d = (kind_q == i2crts_pkg::CMD_WRITE) ?
						i2crts_pkg::PH_DATA : i2crts_pkg::PH_REP;
				end
				i2crts_pkg::PH_DATA: phase_d = i2crts_pkg::PH_IDLE;
				i2crts_pkg::PH_REP:  phase_d = i2crts_pkg::PH_SLAR;
				i2crts_pkg::PH_SLAR: begin
					if (kind_q != i2crts_pkg::CMD_BURST || left_q == CW'(1))
						phase_d = i2crts_pkg::PH_RXNACK;
					else if (left_q == '0)
						phase_d = i2crts_pkg::PH_IDLE;
					else
						phase_d = i2crts_pkg::PH_RXACK;
				end
				i2crts_pkg::PH_RXACK: begin
					left_d  = left_dec;
					phase_d = (left_dec == CW'(1)) ?
						i2crts_pkg::PH_RXNACK : i2crts_pkg::PH_RXACK;
				end
				i2crts_pkg::PH_RXNACK: begin
					left_d  = '0;
					phase_d = i2crts_pkg::PH_IDLE;
				end
				default: phase_d = i2crts_pkg::PH_IDLE;
			endcase
		end
	end

	// result word
	always_comb begin
		res_d = '0;
		if (!is_event) begin
			if (phase_q == i2crts_pkg::PH_IDLE)
				res_d.data.action = i2crts_pkg::ACT_START;
		end else if (phase_q == i2crts_pkg::PH_IDLE) begin
			res_d = '0;
		end else if (!st_ok) begin
			res_d.data.finished = 1'b1;
			case (phase_q)
				i2crts_pkg::PH_START: res_d.data.result_code = i2crts_pkg::RC_START;
				i2crts_pkg::PH_SLAW:  res_d.data.result_code = i2crts_pkg::RC_SLAW;
				i2crts_pkg::PH_REG,
				i2crts_pkg::PH_DATA:  res_d.data.result_code = i2crts_pkg::RC_WRITE;
				i2crts_pkg::PH_REP:   res_d.data.result_code = i2crts_pkg::RC_REPSTART;
				i2crts_pkg::PH_SLAR:  res_d.data.result_code = i2crts_pkg::RC_SLAR;
				i2crts_pkg::PH_RXACK: res_d.data.result_code = i2crts_pkg::RC_ACKERR;
				i2crts_pkg::PH_RXNACK: begin
					res_d.data.result_code = (kind_q == i2crts_pkg::CMD_BURST) ?
						i2crts_pkg::RC_NACK : i2crts_pkg::RC_READ;
				end
				default: res_d.data.finished = 1'b0;
			endcase
		end else begin
			case (phase_q)
				i2crts_pkg::PH_START: begin
					res_d.data.action  = i2crts_pkg::ACT_SEND;
					res_d.data.tx_byte = {sla_q[7:1], 1'b0};
				end
				i2crts_pkg::PH_SLAW: begin
					res_d.data.action  = i2crts_pkg::ACT_SEND;
					res_d.data.tx_byte = (kind_q == i2crts_pkg::CMD_BURST) ?
						(reg_q | i2crts_pkg::BURST_FLAG) : reg_q;
				end
				i2crts_pkg::PH_REG: begin
					if (kind_q == i2crts_pkg::CMD_WRITE) begin
						res_d.data.action  = i2crts_pkg::ACT_SEND;
						res_d.data.tx_byte = pend_q;
					end else begin
						res_d.data.action = i2crts_pkg::ACT_START;
					end
				end
				i2crts_pkg::PH_DATA: begin
					res_d.data.action   = i2crts_pkg::ACT_STOP;
					res_d.data.finished = 1'b1;
				end
				i2crts_pkg::PH_REP: begin
					res_d.data.action  = i2crts_pkg::ACT_SEND;
					res_d.data.tx_byte = {sla_q[7:1], 1'b1};
				end
				i2crts_pkg::PH_SLAR: begin
					if (kind_q != i2crts_pkg::CMD_BURST || left_q == CW'(1)) begin
						res_d.data.action = i2crts_pkg::ACT_NACK;
					end else if (left_q == '0) begin
						// empty burst: stop right after SLA+R
						res_d.data.action   = i2crts_pkg::ACT_STOP;
						res_d.data.finished = 1'b1;
					end else begin
						res_d.data.action = i2crts_pkg::ACT_ACK;
					end
				end
				i2crts_pkg::PH_RXACK: begin
					res_d.data.action  = (left_dec == CW'(1)) ?
						i2crts_pkg::ACT_NACK : i2crts_pkg::ACT_ACK;
					res_d.data.rx_data = in_d.engine_rx_byte;
					res_d.rx_valid     = 1'b1;
				end
				i2crts_pkg::PH_RXNACK: begin
					res_d.data.action   = i2crts_pkg::ACT_STOP;
					res_d.data.rx_data  = in_d.engine_rx_byte;
					res_d.data.finished = 1'b1;
					res_d.rx_valid      = 1'b1;
					res_d.rx_last       = 1'b1;
				end
				default: res_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2crts_pkg::PH_IDLE;
			kind_q  <= i2crts_pkg::CMD_WRITE;
			sla_q   <= '0;
			reg_q   <= '0;
			pend_q  <= '0;
			left_q  <= '0;
		end else if (s_accept) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			sla_q   <= sla_d;
			reg_q   <= reg_d;
			pend_q  <= pend_d;
			left_q  <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_accept) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q.data;
	assign m_tuser  = res_q.rx_valid;
	assign m_tlast  = res_q.rx_last;

endmodule

// ===== rtl/core/i2crts_checker.sv =====
// ----------------------------------------------------------------------------
// i2crts_checker
// Port-level checks of the I2C register transaction sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2crts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	i2crts_pkg::out_data_t od;
	logic                  s_seen;

	assign od     = i2crts_pkg::out_data_t'(m_tdata);
	assign s_seen = s_tvalid && (s_tuser == s_tuser) && (s_tdata == s_tdata);

	// a held output word stays put
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// input side opens whenever the output register is free or draining
	`ASSERT_IMPL(a_ready_path, clk, arst_n, !m_tvalid || m_tready, s_tready)

	// the last read byte carries a byte and closes the transaction with stop
	`ASSERT_IMPL(a_last_byte, clk, arst_n, m_tvalid && m_tlast,
		m_tuser && od.finished && (od.action == i2crts_pkg::ACT_STOP))

	// an error code only comes with completion and no bus action
	`ASSERT_IMPL(a_err_end, clk, arst_n,
		m_tvalid && (od.result_code != i2crts_pkg::RC_OK),
		od.finished && (od.action == i2crts_pkg::ACT_NONE) && !m_tuser)

	// an accepted word always shows a result in the next cycle
	`ASSERT_NEXT(a_one_result, clk, arst_n, s_seen && s_tready, m_tvalid)

endmodule

bind i2c_register_transaction_sequencer i2crts_checker u_i2crts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C register transaction sequencer. Register
// writes, single reads and burst reads are played as request words followed
// by engine status events, mostly well formed, some with a wrong status, a
// request while busy or a status while idle. Every output word is compared
// with an in-bench model of the sequencer, and both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
	import i2crts_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned RANDOM_WORDS = 1600;

	typedef struct {
		cmd_t     cmd;
		in_data_t data;
	} bus_word_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// sequencer model state
	phase_t      seq_phase = PH_IDLE;
	cmd_t        seq_kind  = CMD_WRITE;
	logic [7:0]  seq_sla   = '0;
	logic [7:0]  seq_reg   = '0;
	logic [7:0]  seq_data  = '0;
	logic [15:0] seq_left  = '0;

	bus_word_t   stim_q[$];
	result_t     expected_q[$];
	bus_word_t   cur_word;
	result_t     want;
	out_data_t   got;

	int unsigned src_gap = 0;
	int unsigned sink_stall = 0;
	bit          src_quiet = 1'b0;
	bit          sink_quiet = 1'b0;

	int unsigned err_count = 0;
	int unsigned work_words = 0;
	int unsigned n_ok = 0;
	int unsigned n_abort = 0;
	int unsigned n_ignored = 0;
	int unsigned n_bytes = 0;
	int unsigned n_words = 0;
	int unsigned n_cycles = 0;

	i2c_register_transaction_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	function automatic result_t txn_abort(rcode_t code);
		result_t r;
		r = '0;
		r.data.finished = 1'b1;
		r.data.result_code = code;
		seq_phase = PH_IDLE;
		return r;
	endfunction

	function automatic action_t next_receive();
		if (seq_left == 16'd1) begin
			seq_phase = PH_RXNACK;
			return ACT_NACK;
		end
		seq_phase = PH_RXACK;
		return ACT_ACK;
	endfunction

	// one input word in, one result word out
	function automatic result_t sequencer_step(cmd_t cmd, in_data_t d);
		result_t    r;
		logic [7:0] st;
		r = '0;
		st = d.engine_status & ST_MASK;
		if (cmd != CMD_EVENT) begin
			if (seq_phase == PH_IDLE) begin
				seq_kind = cmd;
				seq_sla = d.device_address;
				seq_reg = d.register_address;
				seq_data = d.write_data;
				seq_left = d.byte_count;
				seq_phase = PH_START;
				r.data.action = ACT_START;
			end
			return r;
		end
		case (seq_phase)
			PH_START: begin
				if (st != ST_START) return txn_abort(RC_START);
				seq_phase = PH_SLAW;
				r.data.action = ACT_SEND;
				r.data.tx_byte = seq_sla & 8'hFE;
			end
			PH_SLAW: begin
				if (st != ST_SLAW_ACK) return txn_abort(RC_SLAW);
				seq_phase = PH_REG;
				r.data.action = ACT_SEND;
				r.data.tx_byte = (seq_kind == CMD_BURST) ? (seq_reg | BURST_FLAG) : seq_reg;
			end
			PH_REG: begin
				if (st != ST_DATA_ACK) return txn_abort(RC_WRITE);
				if (seq_kind == CMD_WRITE) begin
					seq_phase = PH_DATA;
					r.data.action = ACT_SEND;
					r.data.tx_byte = seq_data;
				end else begin
					seq_phase = PH_REP;
					r.data.action = ACT_START;
				end
			end
			PH_DATA: begin
				if (st != ST_DATA_ACK) return txn_abort(RC_WRITE);
				seq_phase = PH_IDLE;
				r.data.action = ACT_STOP;
				r.data.finished = 1'b1;
			end
			PH_REP: begin
				if (st != ST_REPSTART) return txn_abort(RC_REPSTART);
				seq_phase = PH_SLAR;
				r.data.action = ACT_SEND;
				r.data.tx_byte = seq_sla | 8'h01;
			end
			PH_SLAR: begin
				if (st != ST_SLAR_ACK) return txn_abort(RC_SLAR);
				if (seq_kind != CMD_BURST) begin
					seq_phase = PH_RXNACK;
					r.data.action = ACT_NACK;
				end else if (seq_left == 16'd0) begin
					// empty burst: stop right after SLA+R
					seq_phase = PH_IDLE;
					r.data.action = ACT_STOP;
					r.data.finished = 1'b1;
				end else begin
					r.data.action = next_receive();
				end
			end
			PH_RXACK: begin
				if (st != ST_RX_ACK) return txn_abort(RC_ACKERR);
				seq_left = seq_left - 16'd1;
				r.data.action = next_receive();
				r.rx_valid = 1'b1;
				r.data.rx_data = d.engine_rx_byte;
			end
			PH_RXNACK: begin
				if (st != ST_RX_NACK)
					return txn_abort((seq_kind == CMD_BURST) ? RC_NACK : RC_READ);
				seq_phase = PH_IDLE;
				seq_left = '0;
				r.data.action = ACT_STOP;
				r.data.finished = 1'b1;
				r.rx_valid = 1'b1;
				r.rx_last = 1'b1;
				r.data.rx_data = d.engine_rx_byte;
			end
			default: seq_phase = PH_IDLE;
		endcase
		return r;
	endfunction

	function automatic int unsigned pick_gap(bit quiet);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_data_t random_word();
		in_data_t d;
		d.device_address = 8'($urandom_range(0, 255));
		d.register_address = 8'($urandom_range(0, 255));
		d.write_data = 8'($urandom_range(0, 255));
		d.byte_count = 16'($urandom_range(0, 65535));
		d.engine_status = 8'($urandom_range(0, 255));
		d.engine_rx_byte = 8'($urandom_range(0, 255));
		return d;
	endfunction

	// good engine status for step idx of a transaction; cnt is 1 for a single read
	function automatic logic [7:0] step_status(cmd_t kind, int cnt, int idx);
		case (idx)
			0: return ST_START;
			1: return ST_SLAW_ACK;
			2: return ST_DATA_ACK;
			3: return (kind == CMD_WRITE) ? ST_DATA_ACK : ST_REPSTART;
			4: return ST_SLAR_ACK;
			default: return (idx == 4 + cnt) ? ST_RX_NACK : ST_RX_ACK;
		endcase
	endfunction

	function automatic int txn_steps(cmd_t kind, in_data_t req);
		if (kind == CMD_WRITE) return 4;
		if (kind == CMD_READ) return 6;
		return 5 + int'(req.byte_count);
	endfunction

	task automatic push_word(cmd_t c, in_data_t d);
		bus_word_t w;
		w.cmd = c;
		w.data = d;
		stim_q.push_back(w);
	endtask

	// request, then its status events; a bad status at fail_at ends it,
	// a request while busy goes in ahead of step busy_at
	task automatic run_txn(cmd_t kind, in_data_t req, int fail_at, int busy_at);
		int         n_steps;
		int         stop_idx;
		int         cnt;
		in_data_t   ev;
		logic [7:0] good;
		cnt = (kind == CMD_BURST) ? int'(req.byte_count) : 1;
		n_steps = txn_steps(kind, req);
		stop_idx = (fail_at >= 0 && fail_at < n_steps) ? fail_at : n_steps - 1;
		push_word(kind, req);
		for (int i = 0; i <= stop_idx; i++) begin
			if (i == busy_at)
				push_word(cmd_t'($urandom_range(0, 2)), random_word());
			ev = random_word();
			good = step_status(kind, cnt, i);
			if (i == fail_at) begin
				do ev.engine_status = 8'($urandom_range(0, 255));
				while ((ev.engine_status & ST_MASK) == good);
			end else begin
				ev.engine_status = {good[7:3], 3'($urandom_range(0, 7))};
			end
			push_word(CMD_EVENT, ev);
		end
		work_words += stop_idx + 2;
	endtask

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("tb: %s mismatch: expected %0h, got %0h", name, exp_v, act_v);
			err_count++;
		end
	endtask

	// source side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			src_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (stim_q.size() != 0) begin
				cur_word = stim_q.pop_front();
				s_tuser <= cur_word.cmd;
				s_tdata <= cur_word.data;
				s_tvalid <= 1'b1;
				if ($urandom_range(0, 49) == 0) src_quiet <= !src_quiet;
				src_gap <= pick_gap(src_quiet);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_stall <= 0;
		end else if (sink_stall != 0) begin
			sink_stall <= sink_stall - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 49) == 0) sink_quiet <= !sink_quiet;
			sink_stall <= pick_gap(sink_quiet);
		end
	end

	// monitor: check the output word, then predict for the accepted input word
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_words++;
				if (expected_q.size() == 0) begin
					$error("tb: output word %h with nothing expected", m_tdata);
					err_count++;
				end else begin
					want = expected_q.pop_front();
					got = out_data_t'(m_tdata);
					check_field("action", 32'(want.data.action), 32'(got.action));
					check_field("tx_byte", 32'(want.data.tx_byte), 32'(got.tx_byte));
					check_field("rx_valid", 32'(want.rx_valid), 32'(m_tuser));
					check_field("rx_data", 32'(want.data.rx_data), 32'(got.rx_data));
					check_field("rx_last", 32'(want.rx_last), 32'(m_tlast));
					check_field("finished", 32'(want.data.finished), 32'(got.finished));
					check_field("result_code", 32'(want.data.result_code),
						32'(got.result_code));
					if (want.data.finished && want.data.result_code == RC_OK) n_ok++;
					else if (want.data.finished) n_abort++;
					else if (want.data.action == ACT_NONE) n_ignored++;
					if (want.rx_valid) n_bytes++;
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(sequencer_step(cmd_t'(s_tuser), in_data_t'(s_tdata)));
		end
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", n_cycles);
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		cmd_t     kind;
		in_data_t req;
		int       n_steps;
		int       fail_at;
		int       busy_at;
		int       sel;

		// directed: status while idle, write with a request while busy,
		// single read failing on its byte, empty burst, two-byte burst
		push_word(CMD_EVENT, random_word());
		req = '0;
		req.device_address = 8'hFF;
		req.register_address = 8'hFF;
		req.write_data = 8'h00;
		run_txn(CMD_WRITE, req, -1, 2);
		req.device_address = 8'h00;
		req.register_address = 8'h00;
		req.write_data = 8'hFF;
		req.byte_count = 16'hFFFF;
		run_txn(CMD_READ, req, 5, -1);
		req.device_address = 8'hA5;
		req.register_address = 8'h7F;
		req.byte_count = 16'd0;
		run_txn(CMD_BURST, req, -1, -1);
		req.register_address = 8'h80;
		req.byte_count = 16'd2;
		run_txn(CMD_BURST, req, -1, -1);

		work_words = 0;
		while (work_words < RANDOM_WORDS) begin
			if ($urandom_range(0, 14) == 0) push_word(CMD_EVENT, random_word());
			kind = cmd_t'($urandom_range(0, 2));
			req = random_word();
			sel = $urandom_range(0, 9);
			if (sel < 7) req.byte_count = 16'($urandom_range(0, 6));
			else if (sel < 9) req.byte_count = 16'($urandom_range(7, 40));
			n_steps = txn_steps(kind, req);
			// long bursts are always cut short by a bad status
			if (kind == CMD_BURST && req.byte_count > 40) fail_at = $urandom_range(0, 11);
			else if ($urandom_range(0, 4) == 0) fail_at = $urandom_range(0, n_steps - 1);
			else fail_at = -1;
			busy_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1;
			run_txn(kind, req, fail_at, busy_at);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || s_tvalid) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("tb: %0d output words checked in %0d cycles", n_words, n_cycles);
		$display("tb: %0d transactions ok, %0d ended on error, %0d ignored, %0d bytes read",
			n_ok, n_abort, n_ignored, n_bytes);
		if (err_count == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
